>>> sv/vmu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_pkg
// Operation codes, fixed-point format and shared control types of the
// vector math unit.
// ----------------------------------------------------------------------------
package vmu_pkg;

    // fraction bits of every component
    localparam int FRAC_BITS = 16;

    typedef logic [2:0] t_op;

    localparam t_op OP_ADD   = 3'd0;
    localparam t_op OP_SUB   = 3'd1;
    localparam t_op OP_DOT   = 3'd2;
    localparam t_op OP_CROSS = 3'd3;
    localparam t_op OP_LEN   = 3'd4;
    localparam t_op OP_NORM  = 3'd5;

    // per-stage control travelling beside the data
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

endpackage
`default_nettype wire

>>> sv/vmu_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_lane
// One component lane: two signed multipliers and an adder, registered.
// ----------------------------------------------------------------------------
module vmu_lane #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  vmu_pkg::t_op         i_op,
    input  logic signed [W-1:0]  i_a,
    input  logic signed [W-1:0]  i_b,
    input  logic signed [W-1:0]  i_ca,
    input  logic signed [W-1:0]  i_cb,
    input  logic signed [W-1:0]  i_cc,
    input  logic signed [W-1:0]  i_cd,
    output logic signed [2*W-1:0] o_p0,
    output logic signed [2*W-1:0] o_p1,
    output logic signed [W:0]    o_as,
    output logic                 o_neg
);
    import vmu_pkg::*;

    localparam int W2 = 2 * W;
    localparam int W1 = W + 1;

    logic signed [W-1:0] w_x0;
    logic signed [W-1:0] w_y0;
    logic                w_sq;
    logic                w_cross;

    assign w_cross = (i_op == OP_CROSS);
    assign w_sq    = (i_op == OP_LEN) || (i_op == OP_NORM);
    assign w_x0    = w_cross ? i_ca : i_a;
    assign w_y0    = w_cross ? i_cb : (w_sq ? i_a : i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p0  <= W2'(w_x0) * W2'(w_y0);
            o_p1  <= W2'(i_cc) * W2'(i_cd);
            o_as  <= (i_op == OP_SUB) ? (W1'(i_a) - W1'(i_b)) : (W1'(i_a) + W1'(i_b));
            o_neg <= i_a[W-1];
        end
    end

endmodule
`default_nettype wire

>>> sv/vmu_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_merge
// Combines the lane products: sums, rounding, saturation and root set-up.
// ----------------------------------------------------------------------------
module vmu_merge #(
    parameter int W = 32,
    localparam int AW = 2 * W + 2 * vmu_pkg::FRAC_BITS + 4
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  vmu_pkg::t_op          i_op,
    input  logic signed [2*W-1:0] i_p0 [4],
    input  logic signed [2*W-1:0] i_p1 [4],
    input  logic signed [W:0]     i_as [4],
    input  logic [3:0]            i_neg,
    output logic signed [W-1:0]   o_vec [4],
    output logic signed [W-1:0]   o_scalar,
    output logic                  o_sat,
    output logic                  o_zero,
    output logic [3:0]            o_neg,
    output logic                  o_len,
    output logic [AW-1:0]         o_t [4],
    output logic [AW-1:0]         o_div [4]
);
    import vmu_pkg::*;

    localparam int SW = 2 * W + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXP = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] MINN = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    // round half away from zero, dropping the extra fraction bits
    function automatic logic signed [SW-1:0] f_round(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] s;
        s = v + HALF - $signed(SW'(v[SW-1]));
        return s >>> FRAC_BITS;
    endfunction

    // clamp to the component range, flag in the top bit
    function automatic logic [W:0] f_clamp(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > MAXP) begin
            r = {1'b1, MAXP[W-1:0]};
        end else if (v < MINN) begin
            r = {1'b1, MINN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // first merge stage
    logic signed [SW-1:0]  r_sum;
    logic signed [SW-1:0]  r_cr [3];
    logic [2*W-2:0]        r_sq [4];
    logic signed [W:0]     r_as [4];
    logic [3:0]            r_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SW'(i_p0[0]) + SW'(i_p0[1]) + SW'(i_p0[2]) + SW'(i_p0[3]);
            for (int i = 0; i < 3; i++) begin
                r_cr[i] <= SW'(i_p0[i]) - SW'(i_p1[i]);
            end
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= i_p0[i][2*W-2:0];
                r_as[i] <= i_as[i];
            end
            r_neg <= i_neg;
        end
    end

    // second merge stage
    logic [W:0]            w_as_cl [4];
    logic [W:0]            w_cr_cl [3];
    logic [W:0]            w_dot_cl;
    logic [2*W:0]          w_s;
    logic signed [W-1:0]   n_vec [4];
    logic signed [W-1:0]   n_scalar;
    logic                  n_sat;
    logic [AW-1:0]         n_t [4];
    logic [AW-1:0]         n_div [4];

    assign w_dot_cl = f_clamp(f_round(r_sum));
    assign w_s      = r_sum[2*W:0];

    for (genvar i = 0; i < 4; i++) begin : g_as
        assign w_as_cl[i] = f_clamp(SW'(r_as[i]));
    end
    for (genvar i = 0; i < 3; i++) begin : g_cr
        assign w_cr_cl[i] = f_clamp(f_round(r_cr[i]));
    end

    always_comb begin
        n_scalar = '0;
        n_sat    = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_vec[i] = '0;
        end
        case (i_op) inside
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    n_vec[i] = w_as_cl[i][W-1:0];
                    n_sat    = n_sat | w_as_cl[i][W];
                end
            end
            OP_DOT: begin
                n_scalar = w_dot_cl[W-1:0];
                n_sat    = w_dot_cl[W];
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_vec[i] = w_cr_cl[i][W-1:0];
                    n_sat    = n_sat | w_cr_cl[i][W];
                end
            end
            default: ;
        endcase
    end

    // root set-up: length searches sqrt(4s), normalize searches 2|a|/sqrt(s)
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i_op == OP_LEN) begin
                n_t[i]   = (i == 0) ? (AW'(w_s) << 2) : '0;
                n_div[i] = AW'(1);
            end else begin
                n_t[i]   = AW'(r_sq[i]) << (2 * FRAC_BITS + 2);
                n_div[i] = AW'(w_s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vec    <= n_vec;
            o_scalar <= n_scalar;
            o_sat    <= n_sat;
            o_zero   <= (i_op == OP_NORM) && (w_s == '0);
            o_neg    <= r_neg;
            o_len    <= (i_op == OP_LEN);
            o_t      <= n_t;
            o_div    <= n_div;
        end
    end

endmodule
`default_nettype wire

>>> sv/vmu_root.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmu_root
// Pipelined bit search for the largest m with m*m*div <= t, one bit a stage.
// ----------------------------------------------------------------------------
module vmu_root #(
    parameter int W = 32,
    localparam int AW = 2 * W + 2 * vmu_pkg::FRAC_BITS + 4
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_len,
    input  logic [AW-1:0] i_t,
    input  logic [AW-1:0] i_div,
    output logic [W+1:0]  o_m
);
    import vmu_pkg::*;

    localparam int NS = W + 2;
    localparam int MW = W + 2;

    // remainder t - m*m*div, running m*div, divisor, partial m, mode
    logic [AW-1:0] r_d [NS];
    logic [AW-1:0] r_e [NS];
    logic [AW-1:0] r_s [NS];
    logic [MW-1:0] r_c [NS];
    logic          r_len [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int B = W + 1 - k;
        // normalize quotients never reach above this bit
        localparam bit NORM_OK = (B <= FRAC_BITS + 1);

        logic [AW-1:0] w_d;
        logic [AW-1:0] w_e;
        logic [AW-1:0] w_s;
        logic [MW-1:0] w_c;
        logic          w_l;
        logic [AW:0]   w_t;
        logic          w_take;

        if (k == 0) begin : g_first
            assign w_d = i_t;
            assign w_e = '0;
            assign w_s = i_div;
            assign w_c = '0;
            assign w_l = i_len;
        end else begin : g_next
            assign w_d = r_d[k-1];
            assign w_e = r_e[k-1];
            assign w_s = r_s[k-1];
            assign w_c = r_c[k-1];
            assign w_l = r_len[k-1];
        end

        // (c + 2^B)^2 div - c^2 div
        assign w_t    = ({1'b0, w_e} << (B + 1)) + ({1'b0, w_s} << (2 * B));
        assign w_take = (w_l || NORM_OK) && (w_t <= {1'b0, w_d});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k]   <= w_take ? (w_d - w_t[AW-1:0]) : w_d;
                r_e[k]   <= w_take ? (w_e + (w_s << B)) : w_e;
                r_c[k]   <= w_take ? (w_c | (MW'(1) << B)) : w_c;
                r_s[k]   <= w_s;
                r_len[k] <= w_l;
            end
        end
    end

    assign o_m = r_c[NS-1];

endmodule
`default_nettype wire

>>> sv/vector_math_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_math_unit
// Four-lane fixed-point vector unit: add, subtract, dot, cross, length and
// normalize on signed components with 16 fraction bits.
// ----------------------------------------------------------------------------
//
//  channel   dir  width                          beat contents
//  s_axis    in   tdata 8W+3 (byte padded)       dims, a_x..a_w, b_x..b_w
//                 tuser 3                        op
//  m_axis    out  tdata 5W (byte padded)         r_x, r_y, r_z, r_w, scalar_out
//                 tuser 2                        saturated, zero_length
//
//  one beat per cycle in and out unless the skid register is full; stages:
//  operand register, lane multipliers, two merge stages,
//  COMPONENT_BITS + 2 square root stages (one result bit each), output register
//  all stages advance together; they hold only when the skid register is full
//  an output register plus one skid register decouple m_axis from the pipe
//  synchronous active-low reset clears valid and control state only
//
module vector_math_unit #(
    parameter int COMPONENT_BITS = 32,
    localparam int IN_DW  = ((8 * COMPONENT_BITS + 3 + 7) / 8) * 8,
    localparam int OUT_DW = ((5 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // dims, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // op
    input  vmu_pkg::t_op      s_axis_tuser,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // r_x, r_y, r_z, r_w, scalar_out
    output logic [OUT_DW-1:0] m_axis_tdata,
    // saturated, zero_length
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready
);
    import vmu_pkg::*;

    localparam int W  = COMPONENT_BITS;
    localparam int AW = 2 * W + 2 * FRAC_BITS + 4;
    localparam int NS = W + 2;
    localparam int MW = W + 2;
    localparam logic [MW-1:0] MAXP_M = {3'b000, {(W - 1){1'b1}}};
    localparam logic [MW-1:0] MAXN_M = {2'b00, 1'b1, {(W - 1){1'b0}}};
    localparam logic [W-1:0]  MAXP   = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  MINN   = {1'b1, {(W - 1){1'b0}}};
    localparam int RW = 5 * W + 2;

    // global advance: every stage moves unless the skid register holds a beat
    logic r_skid_v;
    logic w_en;
    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    // ---------------- operand stage ----------------
    logic [2:0]          w_dims;
    logic                w_cross;
    logic                w_use_z;
    logic                w_use_w;
    logic signed [W-1:0] w_in_a [4];
    logic signed [W-1:0] w_in_b [4];
    logic signed [W-1:0] r_a [4];
    logic signed [W-1:0] r_b [4];
    t_ctl                r_ctl_a;
    t_ctl                r_ctl_b;
    t_ctl                r_ctl_c;
    t_ctl                r_ctl_d;

    assign w_dims  = s_axis_tdata[2:0];
    assign w_cross = (s_axis_tuser == OP_CROSS);
    // dims below two act as two, above four as four; cross ignores dims
    assign w_use_z = (w_dims >= 3'd3) || w_cross;
    assign w_use_w = (w_dims >= 3'd4) && !w_cross;

    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign w_in_a[i] = s_axis_tdata[3 + i * W +: W];
        assign w_in_b[i] = s_axis_tdata[3 + (4 + i) * W +: W];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a[0] <= w_in_a[0];
            r_a[1] <= w_in_a[1];
            r_a[2] <= w_use_z ? w_in_a[2] : '0;
            r_a[3] <= w_use_w ? w_in_a[3] : '0;
            r_b[0] <= w_in_b[0];
            r_b[1] <= w_in_b[1];
            r_b[2] <= w_use_z ? w_in_b[2] : '0;
            r_b[3] <= w_use_w ? w_in_b[3] : '0;
        end
    end

    // control chain through the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_ctl_d <= '0;
        end else if (w_en) begin
            r_ctl_a <= '{valid: s_axis_tvalid, op: s_axis_tuser};
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
            r_ctl_d <= r_ctl_c;
        end
    end

    // ---------------- lanes ----------------
    // cross partners: lane 0 gives r_x, lane 1 r_y, lane 2 r_z
    logic signed [W-1:0]   w_ca [4];
    logic signed [W-1:0]   w_cb [4];
    logic signed [W-1:0]   w_cc [4];
    logic signed [W-1:0]   w_cd [4];
    logic signed [2*W-1:0] w_p0 [4];
    logic signed [2*W-1:0] w_p1 [4];
    logic signed [W:0]     w_as [4];
    logic [3:0]            w_neg_b;

    assign w_ca[0] = r_a[1];  assign w_cb[0] = r_b[2];
    assign w_cc[0] = r_a[2];  assign w_cd[0] = r_b[1];
    assign w_ca[1] = r_a[2];  assign w_cb[1] = r_b[0];
    assign w_cc[1] = r_a[0];  assign w_cd[1] = r_b[2];
    assign w_ca[2] = r_a[0];  assign w_cb[2] = r_b[1];
    assign w_cc[2] = r_a[1];  assign w_cd[2] = r_b[0];
    assign w_ca[3] = '0;      assign w_cb[3] = '0;
    assign w_cc[3] = '0;      assign w_cd[3] = '0;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        vmu_lane #(
            .W (W)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (r_ctl_a.op),
            .i_a   (r_a[i]),
            .i_b   (r_b[i]),
            .i_ca  (w_ca[i]),
            .i_cb  (w_cb[i]),
            .i_cc  (w_cc[i]),
            .i_cd  (w_cd[i]),
            .o_p0  (w_p0[i]),
            .o_p1  (w_p1[i]),
            .o_as  (w_as[i]),
            .o_neg (w_neg_b[i])
        );
    end

    // ---------------- merge ----------------
    logic signed [W-1:0] w_m_vec [4];
    logic signed [W-1:0] w_m_scalar;
    logic                w_m_sat;
    logic                w_m_zero;
    logic [3:0]          w_m_neg;
    logic                w_m_len;
    logic [AW-1:0]       w_m_t [4];
    logic [AW-1:0]       w_m_div [4];

    vmu_merge #(
        .W (W)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_op     (r_ctl_c.op),
        .i_p0     (w_p0),
        .i_p1     (w_p1),
        .i_as     (w_as),
        .i_neg    (w_neg_b),
        .o_vec    (w_m_vec),
        .o_scalar (w_m_scalar),
        .o_sat    (w_m_sat),
        .o_zero   (w_m_zero),
        .o_neg    (w_m_neg),
        .o_len    (w_m_len),
        .o_t      (w_m_t),
        .o_div    (w_m_div)
    );

    // ---------------- square root lanes ----------------
    logic [MW-1:0] w_m [4];

    for (genvar i = 0; i < 4; i++) begin : g_root
        vmu_root #(
            .W (W)
        ) u_root (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_len ((i == 0) ? w_m_len : 1'b0),
            .i_t   (w_m_t[i]),
            .i_div (w_m_div[i]),
            .o_m   (w_m[i])
        );
    end

    // merged results ride alongside the root stages
    logic                r_vld [NS];
    t_op                 r_dop [NS];
    logic signed [W-1:0] r_dvec [NS][4];
    logic signed [W-1:0] r_dsc [NS];
    logic                r_dsat [NS];
    logic                r_dzero [NS];
    logic [3:0]          r_dneg [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= r_ctl_d.valid;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dop[0]   <= r_ctl_d.op;
            r_dvec[0]  <= w_m_vec;
            r_dsc[0]   <= w_m_scalar;
            r_dsat[0]  <= w_m_sat;
            r_dzero[0] <= w_m_zero;
            r_dneg[0]  <= w_m_neg;
            for (int k = 1; k < NS; k++) begin
                r_dop[k]   <= r_dop[k-1];
                r_dvec[k]  <= r_dvec[k-1];
                r_dsc[k]   <= r_dsc[k-1];
                r_dsat[k]  <= r_dsat[k-1];
                r_dzero[k] <= r_dzero[k-1];
                r_dneg[k]  <= r_dneg[k-1];
            end
        end
    end

    // ---------------- final formatting ----------------
    // the search found floor(2x); (m+1)/2 rounds x half up
    logic [MW:0]   w_inc [4];
    logic [MW-1:0] w_q [4];
    logic [MW-1:0] w_qn [4];
    logic [W-1:0]  w_nv [4];
    logic [3:0]    w_ns;
    logic [W-1:0]  w_len;
    logic          w_len_sat;

    for (genvar i = 0; i < 4; i++) begin : g_fmt
        assign w_inc[i] = {1'b0, w_m[i]} + (MW + 1)'(1);
        assign w_q[i]   = w_inc[i][MW:1];
        assign w_qn[i]  = ~w_q[i] + MW'(1);
        always_comb begin
            if (r_dneg[NS-1][i]) begin
                w_ns[i] = (w_q[i] > MAXN_M);
                w_nv[i] = w_ns[i] ? MINN : w_qn[i][W-1:0];
            end else begin
                w_ns[i] = (w_q[i] > MAXP_M);
                w_nv[i] = w_ns[i] ? MAXP : w_q[i][W-1:0];
            end
        end
    end

    assign w_len_sat = (w_q[0] > MAXP_M);
    assign w_len     = w_len_sat ? MAXP : w_q[0][W-1:0];

    logic [W-1:0] w_f_vec [4];
    logic [W-1:0] w_f_sc;
    logic         w_f_sat;
    logic         w_f_zl;

    always_comb begin
        w_f_sc  = r_dsc[NS-1];
        w_f_sat = r_dsat[NS-1];
        w_f_zl  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_f_vec[i] = r_dvec[NS-1][i];
        end
        case (r_dop[NS-1])
            OP_LEN: begin
                w_f_sc  = w_len;
                w_f_sat = w_len_sat;
            end
            OP_NORM: begin
                // zero-length vector: all zeros, flag only
                if (r_dzero[NS-1]) begin
                    w_f_zl = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        w_f_vec[i] = w_nv[i];
                    end
                    w_f_sat = |w_ns;
                end
            end
            default: ;
        endcase
    end

    logic [RW-1:0] w_fin;
    assign w_fin = {w_f_zl, w_f_sat, w_f_sc, w_f_vec[3], w_f_vec[2], w_f_vec[1], w_f_vec[0]};

    // ---------------- output register and skid ----------------
    logic          r_out_v;
    logic [RW-1:0] r_out;
    logic [RW-1:0] r_skid;
    logic          w_push;

    assign w_push = w_en && r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (m_axis_tready) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (w_push) begin
                if (!r_out_v || m_axis_tready) begin
                    r_out   <= w_fin;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= w_fin;
                    r_skid_v <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_DW'(r_out[5*W-1:0]);
    assign m_axis_tuser  = r_out[RW-1:5*W];

    // ---------------- checks ----------------
    // a beat in the skid register always has one ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    // the skid register fills only behind a stalled output
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("skid register loaded without an output stall");

    // a zero-length result carries zero components and no saturation
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tdata[4*W-1:0] == '0) && !m_axis_tuser[0])
        else $error("zero-length result with non-zero payload");

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vector math unit. A directed table, then random
// vectors; each result beat is checked against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module testbench;
    import vmu_pkg::*;

    localparam int        W          = 32;
    localparam int        IN_DW      = ((8 * W + 3 + 7) / 8) * 8;
    localparam int        OUT_DW     = ((5 * W + 7) / 8) * 8;
    localparam int        N_RANDOM   = 600;
    localparam int        MAX_WAIT   = 18;
    localparam int        DRAIN      = 60;
    localparam longint    CYCLE_CAP  = 400000;
    // codes the unit leaves unused
    localparam t_op       OP_SPARE_A = 3'd6;
    localparam t_op       OP_SPARE_B = 3'd7;
    localparam logic [31:0] MAX_POS  = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG  = 32'h8000_0000;
    localparam logic [31:0] ONE      = 32'h0001_0000;

    typedef struct {
        t_op         op;
        logic [2:0]  dims;
        logic [31:0] a[4];
        logic [31:0] b[4];
    } vec_job;

    typedef struct {
        logic [31:0] r[4];
        logic [31:0] sc;
        bit          sat;
        bit          zl;
    } vec_res;

    typedef struct {
        vec_job job;
        bit     typed;
        vec_res res;
    } stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    t_op               s_axis_tuser = OP_ADD;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;

    vec_res  pending_results[$];
    stim_row rows[$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_sat = 0;
    int      n_zero_len = 0;
    longint  cycle_count = 0;

    vector_math_unit #(.COMPONENT_BITS(W)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [31:0] clamp_mag(bit neg, logic [127:0] m, inout bit sat);
        if (neg) begin
            if (m > 128'h8000_0000) begin
                sat = 1'b1;
                return MAX_NEG;
            end
            return -m[31:0];
        end
        if (m > 128'h7fff_ffff) begin
            sat = 1'b1;
            return MAX_POS;
        end
        return m[31:0];
    endfunction

    // value carries 32 fraction bits; round magnitude, ties away from zero
    function automatic logic [31:0] round_clamp(logic signed [127:0] v, inout bit sat);
        logic [127:0] m;
        bit           neg;
        neg = v < 0;
        m   = neg ? -v : v;
        m   = (m + 128'h8000) >> 16;
        return clamp_mag(neg, m, sat);
    endfunction

    function automatic vec_res predict_vector(vec_job j);
        vec_res              o;
        logic signed [127:0] av[4];
        logic signed [127:0] bv[4];
        logic signed [127:0] raw_a[4];
        logic signed [127:0] raw_b[4];
        logic signed [127:0] acc;
        logic [127:0]        sq;
        logic [127:0]        c;
        logic [127:0]        t;
        logic [127:0]        nn;
        logic [127:0]        q;
        int                  d;
        for (int i = 0; i < 4; i++) o.r[i] = '0;
        o.sc  = '0;
        o.sat = 1'b0;
        o.zl  = 1'b0;
        d = (j.dims < 2) ? 2 : (j.dims > 4) ? 4 : int'(j.dims);
        for (int i = 0; i < 4; i++) begin
            raw_a[i] = $signed(j.a[i]);
            raw_b[i] = $signed(j.b[i]);
            av[i]    = (i < d) ? raw_a[i] : 128'sd0;
            bv[i]    = (i < d) ? raw_b[i] : 128'sd0;
        end
        case (j.op)
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < d; i++) begin
                    acc = (j.op == OP_ADD) ? av[i] + bv[i] : av[i] - bv[i];
                    o.r[i] = clamp_mag(acc < 0, (acc < 0) ? -acc : acc, o.sat);
                end
            end
            OP_DOT: begin
                acc = 0;
                for (int i = 0; i < d; i++) acc += av[i] * bv[i];
                o.sc = round_clamp(acc, o.sat);
            end
            OP_CROSS: begin
                // cross ignores dims and always works on x, y, z
                o.r[0] = round_clamp(raw_a[1] * raw_b[2] - raw_a[2] * raw_b[1], o.sat);
                o.r[1] = round_clamp(raw_a[2] * raw_b[0] - raw_a[0] * raw_b[2], o.sat);
                o.r[2] = round_clamp(raw_a[0] * raw_b[1] - raw_a[1] * raw_b[0], o.sat);
            end
            OP_LEN, OP_NORM: begin
                sq = 0;
                for (int i = 0; i < d; i++) sq += av[i] * av[i];
                if (j.op == OP_LEN) begin
                    q = 0;
                    for (int b = W; b >= 0; b--) begin
                        c = q | (128'd1 << b);
                        if (c * c <= sq) q = c;
                    end
                    if (sq > q * q + q) q++;
                    o.sc = clamp_mag(1'b0, q, o.sat);
                end else if (sq == 0) begin
                    o.zl = 1'b1;
                end else begin
                    for (int i = 0; i < d; i++) begin
                        nn = ((av[i] < 0) ? -av[i] : av[i]) << 16;
                        nn = nn * nn;
                        q  = 0;
                        for (int b = 17; b >= 0; b--) begin
                            c = q | (128'd1 << b);
                            if (c * c * sq <= nn) q = c;
                        end
                        t = 2 * q + 1;
                        if (t * t * sq <= 4 * nn) q++;
                        o.r[i] = clamp_mag(av[i] < 0, q, o.sat);
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------ stimulus

    function automatic vec_job make_job(t_op op, logic [2:0] dims,
                                        logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] az, logic [31:0] aw,
                                        logic [31:0] bx, logic [31:0] by,
                                        logic [31:0] bzc, logic [31:0] bw);
        vec_job j;
        j.op   = op;
        j.dims = dims;
        j.a    = '{ax, ay, az, aw};
        j.b    = '{bx, by, bzc, bw};
        return j;
    endfunction

    function automatic void add_row(vec_job j, bit typed, logic [31:0] rx, logic [31:0] ry,
                                    logic [31:0] rz, logic [31:0] rw, logic [31:0] sc,
                                    bit sat, bit zl);
        stim_row s;
        s.job   = j;
        s.typed = typed;
        s.res.r = '{rx, ry, rz, rw};
        s.res.sc  = sc;
        s.res.sat = sat;
        s.res.zl  = zl;
        rows.push_back(s);
    endfunction

    function automatic void add_model_row(vec_job j);
        add_row(j, 1'b0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    endfunction

    // mix of magnitudes so that rounding, saturation and tiny values all show up
    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h3ffff);
            2: v = -$urandom_range(0, 32'h3ffff);
            3: v = $urandom() >>> $urandom_range(4, 20);
            4: v = $urandom_range(0, 1) ? $urandom() : -($urandom() >> 8);
            default: begin
                case ($urandom_range(0, 5))
                    0: v = MAX_POS;
                    1: v = MAX_NEG;
                    2: v = '0;
                    3: v = 32'hffff_ffff;
                    4: v = ONE;
                    default: v = -ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic vec_job rand_job();
        vec_job j;
        logic [2:0] op_pick;
        op_pick = ($urandom_range(0, 19) == 0) ? t_op'($urandom_range(6, 7))
                                               : t_op'($urandom_range(0, 5));
        j.op   = op_pick;
        // dims outside two to four are clamped by the unit, keep a few
        j.dims = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(2, 4));
        for (int i = 0; i < 4; i++) begin
            j.a[i] = rand_comp();
            j.b[i] = rand_comp();
        end
        // normalize of a zero vector now and then
        if (j.op == OP_NORM && $urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 4; i++) j.a[i] = (i < 2) ? '0 : j.a[i];
            if (j.dims > 2) j.a[2] = '0;
            if (j.dims > 3) j.a[3] = '0;
        end
        return j;
    endfunction

    function automatic void build_directed();
        // saturating add, plain second lane
        add_row(make_job(OP_ADD, 3'd2, MAX_POS, ONE, 5, 5, MAX_POS, ONE, 7, 7), 1'b1,
                MAX_POS, 32'h0002_0000, 0, 0, 0, 1'b1, 1'b0);
        add_row(make_job(OP_SUB, 3'd4, MAX_NEG, 0, 0, ONE, 1, 0, 0, ONE), 1'b1,
                MAX_NEG, 0, 0, 0, 0, 1'b1, 1'b0);
        add_row(make_job(OP_NORM, 3'd3, 0, 0, 0, MAX_POS, 1, 2, 3, 4), 1'b1,
                0, 0, 0, 0, 0, 1'b0, 1'b1);
        add_row(make_job(OP_SPARE_A, 3'd4, MAX_POS, MAX_NEG, 1, 2, 3, 4, 5, 6), 1'b1,
                0, 0, 0, 0, 0, 1'b0, 1'b0);
        add_row(make_job(OP_SPARE_B, 3'd7, MAX_NEG, MAX_NEG, 1, 2, 3, 4, 5, 6), 1'b1,
                0, 0, 0, 0, 0, 1'b0, 1'b0);
        add_row(make_job(OP_LEN, 3'd2, ONE, 0, 9, 9, 0, 0, 0, 0), 1'b1,
                0, 0, 0, 0, ONE, 1'b0, 1'b0);
        add_row(make_job(OP_DOT, 3'd2, ONE, 32'h0002_0000, 1, 1, 32'h0003_0000, ONE, 1, 1),
                1'b1, 0, 0, 0, 0, 32'h0005_0000, 1'b0, 1'b0);
        add_row(make_job(OP_NORM, 3'd2, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0),
                1'b1, 32'h0000_999a, 32'h0000_cccd, 0, 0, 0, 1'b0, 1'b0);
        // extremes and clamped dims, checked against the model
        add_model_row(make_job(OP_DOT, 3'd4, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG,
                               MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG));
        add_model_row(make_job(OP_DOT, 3'd3, MAX_POS, MAX_NEG, 1, 1, MAX_NEG, MAX_POS, 1, 1));
        add_model_row(make_job(OP_CROSS, 3'd2, MAX_NEG, MAX_POS, MAX_NEG, 3,
                               MAX_POS, MAX_NEG, MAX_POS, 4));
        add_model_row(make_job(OP_CROSS, 3'd4, ONE, 0, 0, 0, 0, ONE, 0, 0));
        add_model_row(make_job(OP_LEN, 3'd4, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0));
        add_model_row(make_job(OP_LEN, 3'd3, 1, 1, 1, 0, 0, 0, 0, 0));
        add_model_row(make_job(OP_NORM, 3'd4, MAX_NEG, MAX_POS, 1, 32'hffff_ffff, 0, 0, 0, 0));
        add_model_row(make_job(OP_NORM, 3'd2, 1, 0, 0, 0, 0, 0, 0, 0));
        add_model_row(make_job(OP_NORM, 3'd3, 0, 0, 32'hffff_ffff, 0, 0, 0, 0, 0));
        add_model_row(make_job(OP_ADD, 3'd0, 1, 2, 3, 4, 5, 6, 7, 8));
        add_model_row(make_job(OP_ADD, 3'd1, MAX_NEG, MAX_NEG, 3, 4, MAX_NEG, 6, 7, 8));
        add_model_row(make_job(OP_SUB, 3'd5, MAX_POS, 0, MAX_NEG, MAX_POS,
                               MAX_NEG, 1, 1, 32'hffff_ffff));
        add_model_row(make_job(OP_ADD, 3'd6, MAX_NEG, MAX_POS, MAX_NEG, MAX_NEG,
                               32'hffff_ffff, 1, MAX_NEG, 32'hffff_ffff));
        add_model_row(make_job(OP_DOT, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 32'hffff_ffff));
    endfunction

    // ---------------------------------------------------------------- driver

    bit src_calm = 1'b0;

    task automatic send_job(vec_job j, vec_res exp_res);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // tdata from bit 0 up: dims, a_x..a_w, b_x..b_w
        s_axis_tdata  <= {5'b0, j.b[3], j.b[2], j.b[1], j.b[0],
                          j.a[3], j.a[2], j.a[1], j.a[0], j.dims};
        s_axis_tuser  <= j.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(exp_res);
        n_sent++;
    endtask

    // ------------------------------------------------------------ receiver

    initial begin : sink_stalls
        int  stall;
        bit  calm;
        calm = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        vec_res exp_res;
        vec_res got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            for (int i = 0; i < 4; i++) got.r[i] = m_axis_tdata[32*i +: 32];
            got.sc  = m_axis_tdata[128 +: 32];
            got.sat = m_axis_tuser[0];
            got.zl  = m_axis_tuser[1];
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding");
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                n_sat      += got.sat;
                n_zero_len += got.zl;
                if (got.r[0] !== exp_res.r[0]) begin
                    $error("r_x expected %h got %h", exp_res.r[0], got.r[0]);
                    n_errors++;
                end
                if (got.r[1] !== exp_res.r[1]) begin
                    $error("r_y expected %h got %h", exp_res.r[1], got.r[1]);
                    n_errors++;
                end
                if (got.r[2] !== exp_res.r[2]) begin
                    $error("r_z expected %h got %h", exp_res.r[2], got.r[2]);
                    n_errors++;
                end
                if (got.r[3] !== exp_res.r[3]) begin
                    $error("r_w expected %h got %h", exp_res.r[3], got.r[3]);
                    n_errors++;
                end
                if (got.sc !== exp_res.sc) begin
                    $error("scalar_out expected %h got %h", exp_res.sc, got.sc);
                    n_errors++;
                end
                if (got.sat !== exp_res.sat) begin
                    $error("saturated expected %0b got %0b", exp_res.sat, got.sat);
                    n_errors++;
                end
                if (got.zl !== exp_res.zl) begin
                    $error("zero_length expected %0b got %0b", exp_res.zl, got.zl);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------- sequence

    initial begin : run
        vec_job j;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_directed();
        foreach (rows[k]) begin
            send_job(rows[k].job, rows[k].typed ? rows[k].res : predict_vector(rows[k].job));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 25 == 0) src_calm = ($urandom_range(0, 2) == 0);
            j = rand_job();
            send_job(j, predict_vector(j));
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("%0d vectors sent (%0d directed), %0d results checked",
                 n_sent, rows.size(), n_checked);
        $display("%0d saturating results, %0d zero-length normalizes, %0d errors",
                 n_sat, n_zero_len, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
